// ===== src/gpre_pkg.sv =====
// ---------------------------------------------------------------------------
// gpre_pkg
// Shared types and constants for the gamepad press/release event block.
// ---------------------------------------------------------------------------
package gpre_pkg;

    localparam int NumCodes   = 24;
    localparam int CodeW      = 5;
    localparam int KindW      = 2;
    localparam int AxisW      = 16;
    localparam int TrigW      = 8;
    localparam int DeadzoneW  = 15;
    localparam int ButtonW    = 16;
    localparam int CfgAddrW   = 2;
    localparam int InDataW    = 96;
    localparam int OutDataW   = 88;

    // code map
    localparam int LeftStickBase  = 14;
    localparam int RightStickBase = 18;
    localparam int LeftTrigCode   = 22;
    localparam int RightTrigCode  = 23;

    // configuration register indexes
    localparam logic [CfgAddrW-1:0] CfgLeftDeadzone  = 2'd0;
    localparam logic [CfgAddrW-1:0] CfgRightDeadzone = 2'd1;
    localparam logic [CfgAddrW-1:0] CfgTrigThreshold = 2'd2;

    localparam logic [DeadzoneW-1:0] LeftDeadzoneRst  = 15'd7849;
    localparam logic [DeadzoneW-1:0] RightDeadzoneRst = 15'd8689;
    localparam logic [TrigW-1:0]     TrigThresholdRst = 8'd30;

    // event kinds
    localparam logic [KindW-1:0] EvPress   = 2'd0;
    localparam logic [KindW-1:0] EvRelease = 2'd1;
    localparam logic [KindW-1:0] EvAxes    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_COMPARE,
        ST_EMIT
    } gpre_state_t;

    typedef struct packed {
        logic capture;
        logic square;
        logic compare;
        logic emit;
    } gpre_cmd_t;

    typedef struct packed {
        logic pending;
        logic out_free;
    } gpre_status_t;

endpackage

// ===== src/gpre_ctrl.sv =====
// ---------------------------------------------------------------------------
// gpre_ctrl
// Sequencer: capture a poll, square the axes, classify, then drain events.
// ---------------------------------------------------------------------------
module gpre_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output gpre_pkg::gpre_cmd_t    cmd,
    input  gpre_pkg::gpre_status_t status
);
    import gpre_pkg::*;

    gpre_state_t state_reg;
    gpre_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_COMPARE;
            end
            ST_COMPARE: begin
                cmd.compare = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (!status.pending) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.emit = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/gpre_dp.sv =====
// ---------------------------------------------------------------------------
// gpre_dp
// Datapath: poll capture, stick magnitude, pressed set, event masks and
// the output register.
// ---------------------------------------------------------------------------
module gpre_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  gpre_pkg::gpre_cmd_t                   cmd,
    output gpre_pkg::gpre_status_t                status,
    input  logic [gpre_pkg::InDataW-1:0]         s_tdata,
    input  logic [0:0]                           s_tuser,
    input  logic                                 cfg_wr_en,
    input  logic [gpre_pkg::CfgAddrW-1:0]        cfg_addr,
    input  logic [gpre_pkg::DeadzoneW-1:0]       cfg_wdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [gpre_pkg::OutDataW-1:0]        m_tdata,
    output logic [gpre_pkg::KindW-1:0]           m_tuser,
    output logic                                 m_tlast
);
    import gpre_pkg::*;

    function automatic logic [CodeW-1:0] lowest_set(input logic [NumCodes-1:0] v);
        logic [CodeW-1:0] idx;
        idx = '0;
        for (int i = NumCodes - 1; i >= 0; i--) begin
            if (v[i]) idx = CodeW'(i);
        end
        return idx;
    endfunction

    // one-hot {right, left, down, up}
    function automatic logic [3:0] stick_dir(input logic active,
                                             input logic signed [AxisW-1:0] x,
                                             input logic signed [AxisW-1:0] y);
        logic [AxisW:0] ax;
        logic [AxisW:0] ay;
        logic [3:0]     d;
        ax = x[AxisW-1] ? (AxisW+1)'(-{x[AxisW-1], x}) : {1'b0, x};
        ay = y[AxisW-1] ? (AxisW+1)'(-{y[AxisW-1], y}) : {1'b0, y};
        d  = '0;
        if (active) begin
            if (ax > ay) begin
                if (!x[AxisW-1] && (x != '0)) d[3] = 1'b1;
                else                          d[2] = 1'b1;
            end else begin
                if (!y[AxisW-1] && (y != '0)) d[0] = 1'b1;
                else                          d[1] = 1'b1;
            end
        end
        return d;
    endfunction

    // configuration
    logic [DeadzoneW-1:0] left_dz_reg;
    logic [DeadzoneW-1:0] right_dz_reg;
    logic [TrigW-1:0]     trig_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_dz_reg  <= LeftDeadzoneRst;
            right_dz_reg <= RightDeadzoneRst;
            trig_thr_reg <= TrigThresholdRst;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CfgLeftDeadzone:  left_dz_reg  <= cfg_wdata;
                CfgRightDeadzone: right_dz_reg <= cfg_wdata;
                CfgTrigThreshold: trig_thr_reg <= cfg_wdata[TrigW-1:0];
                default: ;
            endcase
        end
    end

    // captured poll
    logic                     conn_reg;
    logic [ButtonW-1:0]       btn_reg;
    logic [TrigW-1:0]         lt_reg;
    logic [TrigW-1:0]         rt_reg;
    logic signed [AxisW-1:0]  lx_reg;
    logic signed [AxisW-1:0]  ly_reg;
    logic signed [AxisW-1:0]  rx_reg;
    logic signed [AxisW-1:0]  ry_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            conn_reg <= s_tuser[0];
            btn_reg  <= s_tdata[15:0];
            lt_reg   <= s_tdata[23:16];
            rt_reg   <= s_tdata[31:24];
            lx_reg   <= s_tdata[47:32];
            ly_reg   <= s_tdata[63:48];
            rx_reg   <= s_tdata[79:64];
            ry_reg   <= s_tdata[95:80];
        end
    end

    // squares: each operand is at most 2^15 in magnitude
    logic [2*AxisW-2:0]     sq_lx_reg;
    logic [2*AxisW-2:0]     sq_ly_reg;
    logic [2*AxisW-2:0]     sq_rx_reg;
    logic [2*AxisW-2:0]     sq_ry_reg;
    logic [2*DeadzoneW-1:0] sq_ldz_reg;
    logic [2*DeadzoneW-1:0] sq_rdz_reg;
    logic signed [2*AxisW-1:0] p_lx;
    logic signed [2*AxisW-1:0] p_ly;
    logic signed [2*AxisW-1:0] p_rx;
    logic signed [2*AxisW-1:0] p_ry;

    assign p_lx = (2*AxisW)'(lx_reg) * (2*AxisW)'(lx_reg);
    assign p_ly = (2*AxisW)'(ly_reg) * (2*AxisW)'(ly_reg);
    assign p_rx = (2*AxisW)'(rx_reg) * (2*AxisW)'(rx_reg);
    assign p_ry = (2*AxisW)'(ry_reg) * (2*AxisW)'(ry_reg);

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            sq_lx_reg  <= p_lx[2*AxisW-2:0];
            sq_ly_reg  <= p_ly[2*AxisW-2:0];
            sq_rx_reg  <= p_rx[2*AxisW-2:0];
            sq_ry_reg  <= p_ry[2*AxisW-2:0];
            sq_ldz_reg <= (2*DeadzoneW)'(left_dz_reg) * (2*DeadzoneW)'(left_dz_reg);
            sq_rdz_reg <= (2*DeadzoneW)'(right_dz_reg) * (2*DeadzoneW)'(right_dz_reg);
        end
    end

    // classification
    logic [2*AxisW-1:0]  mag_l;
    logic [2*AxisW-1:0]  mag_r;
    logic                act_l;
    logic                act_r;
    logic [NumCodes-1:0] now_set;
    logic [2*TrigW-1:0]  trig_now;
    logic [4*AxisW-1:0]  sticks_now;

    assign mag_l      = {1'b0, sq_lx_reg} + {1'b0, sq_ly_reg};
    assign mag_r      = {1'b0, sq_rx_reg} + {1'b0, sq_ry_reg};
    assign act_l      = mag_l >= (2*AxisW)'(sq_ldz_reg);
    assign act_r      = mag_r >= (2*AxisW)'(sq_rdz_reg);
    assign trig_now   = {rt_reg, lt_reg};
    assign sticks_now = {ry_reg, rx_reg, ly_reg, lx_reg};

    always_comb begin
        now_set        = '0;
        now_set[9:0]   = btn_reg[9:0];
        now_set[13:10] = btn_reg[15:12];
        now_set[LeftStickBase +: 4]  = stick_dir(act_l, lx_reg, ly_reg);
        now_set[RightStickBase +: 4] = stick_dir(act_r, rx_reg, ry_reg);
        now_set[LeftTrigCode]  = lt_reg >= trig_thr_reg;
        now_set[RightTrigCode] = rt_reg >= trig_thr_reg;
    end

    // tracked state and pending events
    logic [NumCodes-1:0] pressed_reg;
    logic                was_conn_reg;
    logic                axes_known_reg;
    logic [2*TrigW-1:0]  last_trig_reg;
    logic [4*AxisW-1:0]  last_sticks_reg;
    logic [NumCodes-1:0] press_reg;
    logic [NumCodes-1:0] rel_reg;
    logic                axes_pend_reg;

    logic                axes_change;
    logic                sel_press;
    logic                sel_rel;
    logic [NumCodes-1:0] press_rem;
    logic [NumCodes-1:0] rel_rem;
    logic [CodeW-1:0]    ev_code;
    logic [KindW-1:0]    ev_kind;
    logic                ev_last;

    assign axes_change = !axes_known_reg || (trig_now != last_trig_reg) ||
                         (sticks_now != last_sticks_reg);
    assign sel_press   = |press_reg;
    assign sel_rel     = !sel_press && (|rel_reg);
    assign press_rem   = press_reg & (press_reg - NumCodes'(1));
    assign rel_rem     = rel_reg & (rel_reg - NumCodes'(1));

    always_comb begin
        if (sel_press) begin
            ev_kind = EvPress;
            ev_code = lowest_set(press_reg);
            ev_last = (press_rem == '0) && (rel_reg == '0) && !axes_pend_reg;
        end else if (sel_rel) begin
            ev_kind = EvRelease;
            ev_code = lowest_set(rel_reg);
            ev_last = (rel_rem == '0) && !axes_pend_reg;
        end else begin
            ev_kind = EvAxes;
            ev_code = '0;
            ev_last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg     <= '0;
            was_conn_reg    <= 1'b0;
            axes_known_reg  <= 1'b0;
            last_trig_reg   <= '0;
            last_sticks_reg <= '0;
            press_reg       <= '0;
            rel_reg         <= '0;
            axes_pend_reg   <= 1'b0;
        end else if (cmd.compare) begin
            if (!conn_reg) begin
                // drop: release everything held, keep last axes
                press_reg     <= '0;
                rel_reg       <= was_conn_reg ? pressed_reg : '0;
                axes_pend_reg <= 1'b0;
                pressed_reg   <= '0;
                was_conn_reg  <= 1'b0;
            end else begin
                press_reg     <= now_set & ~pressed_reg;
                rel_reg       <= pressed_reg & ~now_set;
                axes_pend_reg <= axes_change;
                pressed_reg   <= now_set;
                was_conn_reg  <= 1'b1;
                if (axes_change) begin
                    axes_known_reg  <= 1'b1;
                    last_trig_reg   <= trig_now;
                    last_sticks_reg <= sticks_now;
                end
            end
        end else if (cmd.emit) begin
            if (sel_press) begin
                press_reg <= press_rem;
            end else if (sel_rel) begin
                rel_reg <= rel_rem;
            end else begin
                axes_pend_reg <= 1'b0;
            end
        end
    end

    // output register
    logic m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tuser <= ev_kind;
            m_tlast <= ev_last;
            if (ev_kind == EvAxes) begin
                m_tdata <= {3'b000, ry_reg, rx_reg, ly_reg, lx_reg, rt_reg, lt_reg, ev_code};
            end else begin
                m_tdata <= {(OutDataW-CodeW)'(0), ev_code};
            end
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;
    assign status.pending  = (|press_reg) || (|rel_reg) || axes_pend_reg;

endmodule

// ===== src/gamepad_press_release_events.sv =====
// ---------------------------------------------------------------------------
// gamepad_press_release_events
// Turns controller polls into ordered press, release and axes-changed events.
// ---------------------------------------------------------------------------
// Sequence: a poll's transaction is captured, then the square and classify states
//   run, and the emit state loads one event per cycle into the single output
//   register while that register is free; then the block returns to idle. A new
//   poll is taken only in idle, once every event of the last one is issued.
// Reset: synchronous, active low; clears the pressed set, connection and axes
//   history and restores the deadzone and trigger threshold defaults.
module gamepad_press_release_events (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: buttons[15:0], left_trigger[23:16], right_trigger[31:24],
    //          left_x[47:32], left_y[63:48], right_x[79:64], right_y[95:80]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gpre_pkg::InDataW-1:0]        s_tdata,
    input  logic [0:0]                          s_tuser,   // connected[0]
    // m_tdata: key_code[4:0], out_left_trigger[12:5], out_right_trigger[20:13],
    //          out_left_x[36:21], out_left_y[52:37], out_right_x[68:53],
    //          out_right_y[84:69], zero[87:85]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gpre_pkg::OutDataW-1:0]       m_tdata,
    output logic [gpre_pkg::KindW-1:0]          m_tuser,   // event_kind[1:0]
    output logic                                m_tlast,   // last_of_run
    input  logic                                cfg_wr_en,
    input  logic [gpre_pkg::CfgAddrW-1:0]       cfg_addr,
    input  logic [gpre_pkg::DeadzoneW-1:0]      cfg_wdata
);
    import gpre_pkg::*;

    gpre_cmd_t    cmd;
    gpre_status_t status;

    gpre_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    gpre_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== tb/gpre_event_checker.sv =====
// ---------------------------------------------------------------------------
// gpre_event_checker
// Watches the poll, event and register channels of the gamepad event block,
// predicts the ordered press/release/axes events of every accepted poll and
// compares each event transaction field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module gpre_event_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [gpre_pkg::InDataW-1:0]    s_tdata,
    input  logic [0:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [gpre_pkg::OutDataW-1:0]   m_tdata,
    input  logic [gpre_pkg::KindW-1:0]      m_tuser,
    input  logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [gpre_pkg::CfgAddrW-1:0]   cfg_addr,
    input  logic [gpre_pkg::DeadzoneW-1:0]  cfg_wdata,
    output int                              fail_count,
    output int                              events_due
);
    import gpre_pkg::*;

    localparam int DirUp    = 0;
    localparam int DirDown  = 1;
    localparam int DirLeft  = 2;
    localparam int DirRight = 3;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [CodeW-1:0] code;
        logic [TrigW-1:0] lt;
        logic [TrigW-1:0] rt;
        logic [AxisW-1:0] lx;
        logic [AxisW-1:0] ly;
        logic [AxisW-1:0] rx;
        logic [AxisW-1:0] ry;
        logic             last;
    } gp_event_t;

    gp_event_t expected_events[$];

    // shadow of the block's state and registers
    logic [NumCodes-1:0]    held_codes;
    logic                   link_up;
    logic                   axes_seen;
    logic [2*TrigW-1:0]     prev_trig;
    logic [4*AxisW-1:0]     prev_axes;
    logic [DeadzoneW-1:0]   left_dz;
    logic [DeadzoneW-1:0]   right_dz;
    logic [TrigW-1:0]       trig_thr;

    task automatic report_error(input string msg);
        $display("[%0t] checker: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_error($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    function automatic gp_event_t code_event(input logic [KindW-1:0] kind, input int code);
        gp_event_t ev;
        ev = '0;
        ev.kind = kind;
        ev.code = code[CodeW-1:0];
        return ev;
    endfunction

    // one-hot direction code of a stick, or zero inside the deadzone
    function automatic logic [NumCodes-1:0] stick_code(input logic signed [AxisW-1:0] x,
                                                       input logic signed [AxisW-1:0] y,
                                                       input logic [DeadzoneW-1:0] dz,
                                                       input int base);
        longint mag, lim, ax, ay;
        int dir;
        logic [NumCodes-1:0] hit;
        mag = longint'(x) * longint'(x) + longint'(y) * longint'(y);
        lim = longint'(dz) * longint'(dz);
        ax = (x < 0) ? -longint'(x) : longint'(x);
        ay = (y < 0) ? -longint'(y) : longint'(y);
        hit = '0;
        if (mag >= lim) begin
            if (ax > ay)
                dir = (x > 0) ? DirRight : DirLeft;
            else
                dir = (y > 0) ? DirUp : DirDown;
            hit[base + dir] = 1'b1;
        end
        return hit;
    endfunction

    task automatic predict_poll(input logic conn, input logic [InDataW-1:0] d);
        logic [ButtonW-1:0] btn;
        logic [TrigW-1:0] lt, rt;
        logic [AxisW-1:0] lx, ly, rx, ry;
        logic [NumCodes-1:0] now_codes;
        gp_event_t run_q[$];
        gp_event_t ev;
        btn = d[15:0];
        lt  = d[23:16];
        rt  = d[31:24];
        lx  = d[47:32];
        ly  = d[63:48];
        rx  = d[79:64];
        ry  = d[95:80];
        if (!conn) begin
            // a drop releases everything; absent-while-absent is silent
            if (link_up) begin
                for (int c = 0; c < NumCodes; c++)
                    if (held_codes[c])
                        run_q.push_back(code_event(EvRelease, c));
                held_codes = '0;
                link_up = 1'b0;
            end
        end else begin
            link_up = 1'b1;
            now_codes = '0;
            now_codes[9:0]   = btn[9:0];
            now_codes[13:10] = btn[15:12];
            now_codes |= stick_code(lx, ly, left_dz, LeftStickBase);
            now_codes |= stick_code(rx, ry, right_dz, RightStickBase);
            if (lt >= trig_thr)
                now_codes[LeftTrigCode] = 1'b1;
            if (rt >= trig_thr)
                now_codes[RightTrigCode] = 1'b1;
            for (int c = 0; c < NumCodes; c++)
                if (now_codes[c] && !held_codes[c])
                    run_q.push_back(code_event(EvPress, c));
            for (int c = 0; c < NumCodes; c++)
                if (held_codes[c] && !now_codes[c])
                    run_q.push_back(code_event(EvRelease, c));
            held_codes = now_codes;
            if (!axes_seen || {rt, lt} != prev_trig || {ry, rx, ly, lx} != prev_axes) begin
                axes_seen = 1'b1;
                prev_trig = {rt, lt};
                prev_axes = {ry, rx, ly, lx};
                ev = code_event(EvAxes, 0);
                ev.lt = lt;
                ev.rt = rt;
                ev.lx = lx;
                ev.ly = ly;
                ev.rx = rx;
                ev.ry = ry;
                run_q.push_back(ev);
            end
        end
        foreach (run_q[i]) begin
            ev = run_q[i];
            ev.last = (i == run_q.size() - 1);
            expected_events.push_back(ev);
        end
    endtask

    task automatic check_event();
        gp_event_t want;
        if (expected_events.size() == 0) begin
            report_error($sformatf("event with none expected: kind %0d code %0d",
                                   m_tuser, m_tdata[4:0]));
        end else begin
            want = expected_events.pop_front();
            check_field("event_kind", m_tuser, want.kind);
            check_field("key_code", m_tdata[4:0], want.code);
            check_field("left_trigger", m_tdata[12:5], want.lt);
            check_field("right_trigger", m_tdata[20:13], want.rt);
            check_field("left_x", m_tdata[36:21], want.lx);
            check_field("left_y", m_tdata[52:37], want.ly);
            check_field("right_x", m_tdata[68:53], want.rx);
            check_field("right_y", m_tdata[84:69], want.ry);
            check_field("tdata pad", m_tdata[87:85], 0);
            check_field("last_of_run", m_tlast, want.last);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_codes = '0;
            link_up    = 1'b0;
            axes_seen  = 1'b0;
            prev_trig  = '0;
            prev_axes  = '0;
            left_dz    = LeftDeadzoneRst;
            right_dz   = RightDeadzoneRst;
            trig_thr   = TrigThresholdRst;
            expected_events.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_event();
            if (s_tvalid && s_tready)
                predict_poll(s_tuser[0], s_tdata);
            // register takes effect after this edge's poll
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CfgLeftDeadzone: left_dz = cfg_wdata;
                    CfgRightDeadzone: right_dz = cfg_wdata;
                    CfgTrigThreshold: trig_thr = cfg_wdata[TrigW-1:0];
                    default: ;
                endcase
            end
        end
        events_due = expected_events.size();
    end

endmodule

// ===== tb/tb_gamepad_press_release_events.sv =====
// ---------------------------------------------------------------------------
// tb_gamepad_press_release_events
// Drives controller polls and register writes into the gamepad event block:
// a directed pass over buttons, trigger and deadzone edges and connect/drop
// cases, then random poll phases under varied idling, output stalls and register settings.
// Checking is done by gpre_event_checker; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_gamepad_press_release_events;
    import gpre_pkg::*;

    localparam logic [CfgAddrW-1:0] CfgUnused = 2'd3;
    localparam int PhaseItems = 125;
    localparam int NumPhases  = 4;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [InDataW-1:0]     s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OutDataW-1:0]    m_tdata;
    logic [KindW-1:0]       m_tuser;
    logic                   m_tlast;
    logic                   cfg_wr_en;
    logic [CfgAddrW-1:0]    cfg_addr;
    logic [DeadzoneW-1:0]   cfg_wdata;
    int                     fail_count;
    int                     events_due;

    int idle_pct;
    int stall_pct;

    // last poll sent and current register values, for random mutation
    logic [ButtonW-1:0] cur_btn;
    logic [TrigW-1:0]   cur_lt, cur_rt;
    logic [AxisW-1:0]   cur_lx, cur_ly, cur_rx, cur_ry;
    int                 cur_ldz, cur_rdz, cur_thr;

    logic [AxisW-1:0] axis_extremes[3] = '{16'h8000, 16'h7FFF, 16'h0000};

    int idle_by_phase[NumPhases]  = '{0, 80, 0, 30};
    int stall_by_phase[NumPhases] = '{0, 0, 80, 30};

    gamepad_press_release_events u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    gpre_event_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .events_due (events_due)
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_poll(input logic conn, input logic [ButtonW-1:0] btn,
                             input logic [TrigW-1:0] lt, input logic [TrigW-1:0] rt,
                             input logic [AxisW-1:0] lx, input logic [AxisW-1:0] ly,
                             input logic [AxisW-1:0] rx, input logic [AxisW-1:0] ry);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= conn;
        s_tdata  <= {ry, rx, ly, lx, rt, lt, btn};
        cur_btn = btn;
        cur_lt  = lt;
        cur_rt  = rt;
        cur_lx  = lx;
        cur_ly  = ly;
        cur_rx  = rx;
        cur_ry  = ry;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off until every predicted event is out, then let the block go idle
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (events_due != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CfgAddrW-1:0] addr, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value[DeadzoneW-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input int ldz, input int rdz, input int thr);
        cfg_write(CfgLeftDeadzone, ldz);
        cfg_write(CfgRightDeadzone, rdz);
        cfg_write(CfgTrigThreshold, thr);
        cur_ldz = ldz;
        cur_rdz = rdz;
        cur_thr = thr;
    endtask

    function automatic logic [TrigW-1:0] random_trigger();
        int v;
        if ($urandom_range(2) != 0)
            return TrigW'($urandom);
        v = cur_thr + int'($urandom_range(4)) - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[TrigW-1:0];
    endfunction

    task automatic random_stick(input int dz, output logic [AxisW-1:0] x,
                                output logic [AxisW-1:0] y);
        int r;
        logic [AxisW-1:0] t;
        case ($urandom_range(3))
            0: begin
                x = AxisW'($urandom);
                y = AxisW'($urandom);
            end
            1: begin
                // radius right around the deadzone edge
                r = dz + int'($urandom_range(4)) - 2;
                if (r < 0) r = 0;
                if (r > 32767) r = 32767;
                x = AxisW'($urandom_range(1) ? -r : r);
                y = AxisW'($urandom_range(r / 8));
                if ($urandom_range(1)) y = -y;
                if ($urandom_range(1)) begin
                    t = x;
                    x = y;
                    y = t;
                end
            end
            2: begin
                x = AxisW'(int'($urandom_range(6)) - 3);
                y = AxisW'(int'($urandom_range(6)) - 3);
            end
            default: begin
                x = axis_extremes[$urandom_range(2)];
                y = axis_extremes[$urandom_range(2)];
            end
        endcase
    endtask

    task automatic random_poll();
        logic conn;
        logic [ButtonW-1:0] btn;
        logic [TrigW-1:0] lt, rt;
        logic [AxisW-1:0] lx, ly, rx, ry;
        int k;
        conn = ($urandom_range(99) < 90);
        btn = cur_btn;
        case ($urandom_range(3))
            0: btn = cur_btn;
            1: begin
                k = $urandom_range(15);
                btn[k] = ~btn[k];
            end
            2: btn = ButtonW'($urandom);
            default: btn = cur_btn ^ ButtonW'($urandom & $urandom);
        endcase
        lt = cur_lt;
        rt = cur_rt;
        if ($urandom_range(99) < 60) begin
            lt = random_trigger();
            rt = random_trigger();
        end
        lx = cur_lx;
        ly = cur_ly;
        rx = cur_rx;
        ry = cur_ry;
        if ($urandom_range(99) < 60)
            random_stick(cur_ldz, lx, ly);
        if ($urandom_range(99) < 60)
            random_stick(cur_rdz, rx, ry);
        send_poll(conn, btn, lt, rt, lx, ly, rx, ry);
    endtask

    initial begin
        #1000000;
        $display("gamepad_press_release_events regression: fail");
        $finish;
    end

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        idle_pct  = 0;
        stall_pct = 0;
        cur_btn   = '0;
        cur_lt    = '0;
        cur_rt    = '0;
        cur_lx    = '0;
        cur_ly    = '0;
        cur_rx    = '0;
        cur_ry    = '0;
        cur_ldz   = int'(LeftDeadzoneRst);
        cur_rdz   = int'(RightDeadzoneRst);
        cur_thr   = int'(TrigThresholdRst);
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // reset defaults: absent at reset, then first connect with all zeros
        send_poll(1'b0, 16'hFFFF, 8'd255, 8'd255, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        send_poll(1'b1, 16'h0000, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_poll(1'b1, 16'h0000, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_poll(1'b1, 16'hFFFF, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        // only the unused button bits
        send_poll(1'b1, 16'h0C00, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        // trigger threshold edges
        send_poll(1'b1, 16'h0000, 8'd30, 8'd29, 16'd0, 16'd0, 16'd0, 16'd0);
        send_poll(1'b1, 16'h0000, 8'd29, 8'd30, 16'd0, 16'd0, 16'd0, 16'd0);
        // deadzone edge on one axis
        send_poll(1'b1, 16'h0000, 8'd0, 8'd0, 16'd7849, 16'd0, 16'd0, 16'd0);
        send_poll(1'b1, 16'h0000, 8'd0, 8'd0, 16'd7848, 16'd0, 16'd0, 16'd0);
        send_poll(1'b1, 16'h0000, 8'd0, 8'd0, 16'h8000, 16'd0, 16'd0, 16'h8000);
        send_poll(1'b1, 16'h0000, 8'd0, 8'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'd0);
        // diagonals just inside and just past the deadzone; ties go vertical
        send_poll(1'b1, 16'h0000, 8'd0, 8'd0, -16'sd5000, -16'sd5000, 16'd6144, 16'd6144);
        send_poll(1'b1, 16'h0000, 8'd0, 8'd0, -16'sd5600, -16'sd5600, 16'd6145, 16'd6145);
        send_poll(1'b1, 16'hFFFF, 8'd255, 8'd255, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        // drop, stay absent, reconnect with the same axes
        send_poll(1'b0, 16'h0000, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_poll(1'b0, 16'hFFFF, 8'd9, 8'd9, 16'd1, 16'd1, 16'd1, 16'd1);
        send_poll(1'b1, 16'hFFFF, 8'd255, 8'd255, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        settle();

        // zero deadzones and threshold; the unused index must change nothing
        set_config(0, 0, 0);
        cfg_write(CfgUnused, 32'h7FFF);
        send_poll(1'b1, 16'h0000, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_poll(1'b1, 16'h0000, 8'd255, 8'd255, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        settle();

        set_config(32767, 32767, 255);
        send_poll(1'b1, 16'h0000, 8'd254, 8'd255, 16'h7FFF, 16'd0, 16'h8000, 16'h8000);
        send_poll(1'b1, 16'h0000, 8'd255, 8'd0, 16'd23170, 16'd23170, 16'd0, 16'd0);
        settle();

        for (int ph = 0; ph < NumPhases; ph++) begin
            case (ph)
                0: set_config(1234, 20000, 128);
                2: set_config(int'(LeftDeadzoneRst), int'(RightDeadzoneRst),
                              int'(TrigThresholdRst));
                default: set_config($urandom_range(32767), $urandom_range(32767),
                                    $urandom_range(255));
            endcase
            idle_pct  = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            for (int i = 0; i < PhaseItems; i++)
                random_poll();
            settle();
        end

        if (fail_count == 0 && events_due == 0)
            $display("gamepad_press_release_events regression: pass");
        else
            $display("gamepad_press_release_events regression: fail");
        $finish;
    end

endmodule
